// ===== src/text_console_writer_assert.svh =====
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, clocked on clk, held off while rst is high
`define TCW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, held off while rst is high
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

  // Fixed field widths
  localparam int FUNC_W  = 2;
  localparam int CODE_W  = 8;
  localparam int ADDR_W  = 11;
  localparam int POS_W   = 11;
  localparam int DATA_W  = 16;
  localparam int ATTR_W  = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Character codes
  localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE     = 8'h20;

  localparam int TAB_STOP = 8;

  // Register reset values and the blank cell laid down by the power-up sweep
  localparam logic [ATTR_W-1:0] CHAR_ATTR_RESET  = 8'h07;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'h0F;
  localparam logic [DATA_W-1:0] RESET_BLANK      = {BLANK_ATTR_RESET, CH_SPACE};

  // Register indexes (paddr bit 2)
  localparam logic REG_CHAR_ATTR  = 1'b0;
  localparam logic REG_BLANK_ATTR = 1'b1;

  // Which sweep the datapath runs over the cell store
  typedef enum logic [1:0] {
    SWEEP_NONE,
    SWEEP_INIT,
    SWEEP_BLANK,
    SWEEP_SCROLL
  } sweep_mode_t;

  typedef struct packed {
    logic        accept;
    logic        load_read;
    sweep_mode_t sweep_mode;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic sweep_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/tcw_ram.sv =====
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/tcw_datapath.sv =====
`default_nettype none

module tcw_datapath #(
  parameter int NUM_COLUMNS = 80,
  parameter int NUM_ROWS    = 25
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tcw_pkg::ctrl_cmd_t           cmd,
  output tcw_pkg::dp_status_t               status,
  input  wire logic [tcw_pkg::FUNC_W-1:0]   func,
  input  wire logic [tcw_pkg::CODE_W-1:0]   char_code,
  input  wire logic [tcw_pkg::ADDR_W-1:0]   cell_address,
  input  wire logic [tcw_pkg::ATTR_W-1:0]   char_attr,
  input  wire logic [tcw_pkg::ATTR_W-1:0]   blank_attr,
  output logic      [tcw_pkg::POS_W-1:0]    cursor_position,
  output logic      [tcw_pkg::DATA_W-1:0]   cell_data,
  output logic                              scrolled
);

  import tcw_pkg::*;

  localparam int CELL_COUNT = NUM_COLUMNS * NUM_ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(CELL_COUNT + 1);
  localparam int COLW       = $clog2(NUM_COLUMNS);
  localparam int ROWW       = $clog2(NUM_ROWS);
  localparam int COLTW      = COLW + 1;
  localparam int ROWTW      = ROWW + 1;
  localparam int COPY_N     = (NUM_ROWS - 1) * NUM_COLUMNS;
  localparam int CMPW       = (AW > ADDR_W) ? AW : ADDR_W;

  // Cursor
  logic [COLW-1:0]   col;
  logic [ROWW-1:0]   row;
  logic [COLW-1:0]   col_next;
  logic [ROWW-1:0]   row_next;
  logic [COLTW-1:0]  col_t;
  logic [ROWTW-1:0]  row_t;
  logic              put_write;
  logic              need_scroll;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     next_addr;

  // Sweep counter and read bookkeeping
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_prev;
  logic [CW-1:0]     cnt_src;
  logic              sweep_done;
  logic              in_range;
  logic              in_range_q;

  // Store ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Result register
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] data_q;
  logic              scrolled_q;

  function automatic logic [AW-1:0] lin(input logic [ROWW-1:0] r, input logic [COLW-1:0] c);
    return AW'(r) * AW'(NUM_COLUMNS) + AW'(c);
  endfunction

  // Put-char cursor movement
  always_comb begin
    col_t       = {1'b0, col};
    row_t       = {1'b0, row};
    put_write   = 1'b0;
    need_scroll = 1'b0;
    case (char_code)
      CH_BACKSPACE: begin
        if (col != '0) col_t = col_t - 1'b1;
      end
      CH_TAB: begin
        col_t = (col_t + COLTW'(TAB_STOP)) & ~COLTW'(TAB_STOP - 1);
      end
      CH_CR: begin
        col_t = '0;
      end
      CH_LF: begin
        col_t = '0;
        row_t = row_t + 1'b1;
      end
      default: begin
        // printable ASCII only; the top half of the byte range is ignored
        if (!char_code[CODE_W-1] && char_code >= CH_SPACE) begin
          put_write = 1'b1;
          col_t     = col_t + 1'b1;
        end
      end
    endcase
    if (col_t >= COLTW'(NUM_COLUMNS)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
    if (row_t >= ROWTW'(NUM_ROWS)) begin
      need_scroll = 1'b1;
      row_t       = ROWTW'(NUM_ROWS - 1);
    end
  end

  assign col_next  = col_t[COLW-1:0];
  assign row_next  = row_t[ROWW-1:0];
  assign cur_addr  = lin(row, col);
  assign next_addr = lin(row_next, col_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.accept && func == FUNC_PUT) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Sweep counter: cell cnt-1 is written while cnt runs 1..CELL_COUNT
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.sweep_mode == SWEEP_NONE) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 1'b1;
    end
  end

  assign sweep_done = (cnt == CW'(CELL_COUNT));
  assign cnt_prev   = cnt - 1'b1;
  assign cnt_src    = cnt + CW'(NUM_COLUMNS);
  assign in_range   = CMPW'(cell_address) < CMPW'(CELL_COUNT);

  // Store port muxing: sweeps own the write port, else a printable put
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {char_attr, char_code};
    ram_raddr = AW'(cell_address);
    if (cmd.sweep_mode != SWEEP_NONE) begin
      ram_we    = (cnt != '0);
      ram_waddr = cnt_prev[AW-1:0];
      case (cmd.sweep_mode)
        SWEEP_INIT:   ram_wdata = RESET_BLANK;
        SWEEP_SCROLL: ram_wdata = (cnt <= CW'(COPY_N)) ? ram_rdata : {blank_attr, CH_SPACE};
        default:      ram_wdata = {blank_attr, CH_SPACE};
      endcase
      // scroll copy reads one row below the cell written next cycle
      if (cmd.sweep_mode == SWEEP_SCROLL && cnt < CW'(COPY_N)) begin
        ram_raddr = cnt_src[AW-1:0];
      end
    end else if (cmd.accept && func == FUNC_PUT && put_write) begin
      ram_we = 1'b1;
    end
  end

  tcw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELL_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_range_q <= in_range;
    end
    if (cmd.load_read) begin
      pos_q      <= POS_W'(cur_addr);
      data_q     <= in_range_q ? ram_rdata : '0;
      scrolled_q <= 1'b0;
    end else if (cmd.accept && func != FUNC_READ) begin
      pos_q      <= (func == FUNC_PUT) ? POS_W'(next_addr) : POS_W'(cur_addr);
      data_q     <= '0;
      scrolled_q <= (func == FUNC_PUT) && need_scroll;
    end
  end

  assign cursor_position    = pos_q;
  assign cell_data          = data_q;
  assign scrolled           = scrolled_q;
  assign status.need_scroll = need_scroll;
  assign status.sweep_done  = sweep_done;

endmodule

`default_nettype wire

// ===== src/tcw_ctrl.sv =====
`default_nettype none

`include "text_console_writer_assert.svh"

module tcw_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_ready,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  input  wire logic [tcw_pkg::FUNC_W-1:0] func,
  input  wire tcw_pkg::dp_status_t        status,
  output tcw_pkg::ctrl_cmd_t              cmd
);

  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_CLEAR,
    S_SCROLL
  } state_t;

  state_t state;
  state_t state_next;
  logic   result_valid_next;
  logic   accept;

  // Take a new item when idle and the result slot is free or draining
  assign item_ready = (state == S_IDLE) && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;

  // Next state and result-valid
  always_comb begin
    state_next        = state;
    result_valid_next = result_valid;
    if (result_ready) result_valid_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_PUT:   state_next = status.need_scroll ? S_SCROLL : S_IDLE;
            FUNC_CLEAR: state_next = S_CLEAR;
            FUNC_READ:  state_next = S_READ;
            default:    state_next = S_IDLE;
          endcase
          if (func != FUNC_READ) result_valid_next = 1'b1;
        end
      end
      S_READ: begin
        state_next        = S_IDLE;
        result_valid_next = 1'b1;
      end
      S_INIT, S_CLEAR, S_SCROLL: begin
        if (status.sweep_done) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd.accept    = accept;
    cmd.load_read = (state == S_READ);
    case (state)
      S_INIT:   cmd.sweep_mode = SWEEP_INIT;
      S_CLEAR:  cmd.sweep_mode = SWEEP_BLANK;
      S_SCROLL: cmd.sweep_mode = SWEEP_SCROLL;
      default:  cmd.sweep_mode = SWEEP_NONE;
    endcase
  end

  `TCW_ASSERT_IMPLY(a_result_source, $rose(result_valid), $past(accept) || $past(state == S_READ), "result appeared without a transaction")
  `TCW_ASSERT_IMPLY(a_done_in_sweep, status.sweep_done, state == S_INIT || state == S_CLEAR || state == S_SCROLL, "sweep counter ran outside a sweep")
  `TCW_ASSERT_NEXT(a_read_result, state == S_READ, result_valid, "read data not presented")
  `TCW_ASSERT_NEXT(a_clear_sweeps, accept && func == FUNC_CLEAR, state == S_CLEAR, "clear did not start a sweep")

endmodule

`default_nettype wire

// ===== src/text_console_writer.sv =====
// Text console writer: an NUM_COLUMNS x NUM_ROWS store of 16-bit cells
// (attribute in the high byte, character in the low byte) with a cursor.
// func 0 puts one byte (backspace, tab, CR, LF, or printable 0x20-0x7F),
// func 1 blanks every cell, func 2 reads one cell; every result carries the
// linear cursor position row*NUM_COLUMNS+col. A put that neither scrolls
// nor clears leaves the writer idle, so such items can be taken every cycle
// while results are drained; a read holds off the next item through S_READ,
// the registered store read. A clear or a put that scrolls holds off the
// next transaction until a sweep has written every cell, one cell per cycle,
// set by the single write port of the cell store. After reset the store is
// swept to blank (attribute 0x0F, space) before the first item is taken;
// register writes are taken at any time.
`default_nettype none

module text_console_writer #(
  parameter int NUM_COLUMNS = 80,
  parameter int NUM_ROWS    = 25
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // item channel
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire logic [tcw_pkg::FUNC_W-1:0]  func,
  input  wire logic [tcw_pkg::CODE_W-1:0]  char_code,
  input  wire logic [tcw_pkg::ADDR_W-1:0]  cell_address,
  // result channel
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output logic      [tcw_pkg::POS_W-1:0]   cursor_position,
  output logic      [tcw_pkg::DATA_W-1:0]  cell_data,
  output logic                             scrolled,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [tcw_pkg::PDATA_W-1:0] pwdata,
  output logic      [tcw_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);

  import tcw_pkg::*;

  logic [ATTR_W-1:0] char_attr;
  logic [ATTR_W-1:0] blank_attr;
  logic              reg_write;
  ctrl_cmd_t         cmd;
  dp_status_t        status;

  // Register file
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_attr  <= CHAR_ATTR_RESET;
      blank_attr <= BLANK_ATTR_RESET;
    end else if (reg_write) begin
      case (paddr[2])
        REG_CHAR_ATTR:  char_attr  <= pwdata[ATTR_W-1:0];
        REG_BLANK_ATTR: blank_attr <= pwdata[ATTR_W-1:0];
        default:        char_attr  <= char_attr;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CHAR_ATTR:  prdata = PDATA_W'(char_attr);
      REG_BLANK_ATTR: prdata = PDATA_W'(blank_attr);
      default:        prdata = '0;
    endcase
  end

  tcw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .func         (func),
    .status       (status),
    .cmd          (cmd)
  );

  tcw_datapath #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .func            (func),
    .char_code       (char_code),
    .cell_address    (cell_address),
    .char_attr       (char_attr),
    .blank_attr      (blank_attr),
    .cursor_position (cursor_position),
    .cell_data       (cell_data),
    .scrolled        (scrolled)
  );

endmodule

`default_nettype wire
